// ----- rtl/drmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package drmq_pkg;

  // Field widths of one rectangle and of the reported count.
  localparam int unsigned CoordW = 8;
  localparam int unsigned RectW  = 4 * CoordW;
  localparam int unsigned PendW  = 4;

  // Configuration register indexes.
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [CoordW-1:0] ScreenWidthRst  = 8'd80;
  localparam logic [CoordW-1:0] ScreenHeightRst = 8'd25;

  // Packed rectangle as held in the store (x in the low byte).
  typedef struct packed {
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } rect_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DEQ_RD   = 6'b000010,
    ST_DEQ_DATA = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CMP = 6'b010000,
    ST_ADD_END  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/drmq_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface drmq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rect_x;
  logic [7:0] rect_y;
  logic [7:0] rect_w;
  logic [7:0] rect_h;
  modport source (output valid, cmd, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, cmd, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface drmq_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic       full_update;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic [7:0] out_w;
  logic [7:0] out_h;
  logic [3:0] pending_count;
  modport source (output valid, found, full_update, out_x, out_y, out_w, out_h,
                  pending_count, input ready);
  modport sink (input valid, found, full_update, out_x, out_y, out_w, out_h,
                pending_count, output ready);
endinterface

interface drmq_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dirty_rectangle_merge_queue_top.sv -----
// A dequeue reads the head in ST_DEQ_RD and ST_DEQ_DATA, but answers straight from idle for
// an empty list or a full update. An add reads and compares each stored entry per pass;
// a merge starts another pass with one entry fewer, and a new entry is written in ST_ADD_END.
// One item is handled at a time: input ready is high only in idle with no result held back.
// Reset: asynchronous, active low; the list is empty, no full update is pending and
// the screen is 80 by 25. Store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module dirty_rectangle_merge_queue_top
  import drmq_pkg::*;
#(
  parameter int unsigned MAX_RECTS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  drmq_in_if.sink    in_i,
  drmq_out_if.source out_o,
  drmq_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(MAX_RECTS);
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RECTS);

  // Configuration registers.
  logic [CoordW-1:0] scr_w_q, scr_h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= ScreenWidthRst;
      scr_h_q <= ScreenHeightRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_i.data;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_i.data;
        default:           scr_w_q <= scr_w_q;
      endcase
    end
  end

  // Control state.
  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           full_q, full_d;
  logic [CW-1:0]  idx_q, idx_d;
  rect_t          cur_q, cur_d;
  rect_t          mrg_q, mrg_d;
  logic           hit_q, hit_d;
  logic [CW-1:0]  hit_pos_q, hit_pos_d;
  logic           ident_q, ident_d;

  // Result holding register and the output register.
  logic           done_q, done_d;
  logic           res_found_q, res_found_d;
  logic           res_full_q, res_full_d;
  rect_t          res_rect_q, res_rect_d;
  logic           ovalid_q;

  // Store and list order.
  logic           ord_drop, ord_insert;
  logic [CW-1:0]  ord_pos;
  logic [AW-1:0]  slot;
  logic           ram_we;
  rect_t          ram_rdata;

  drmq_order #(.MaxRects(MAX_RECTS)) u_order (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .drop_i   (ord_drop),
    .insert_i (ord_insert),
    .pos_i    (ord_pos),
    .slot_o   (slot)
  );

  drmq_ram #(.Width(RectW), .Depth(MAX_RECTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (cur_q),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // Clipping of an incoming rectangle.
  logic [CoordW:0] in_x2, in_y2;
  logic            in_drop;
  rect_t           in_clip;

  always_comb begin
    in_x2   = {1'b0, in_i.rect_x} + {1'b0, in_i.rect_w};
    in_y2   = {1'b0, in_i.rect_y} + {1'b0, in_i.rect_h};
    in_drop = (in_i.rect_w == '0) || (in_i.rect_h == '0) ||
              (in_i.rect_x >= scr_w_q) || (in_i.rect_y >= scr_h_q);
    in_clip.x = in_i.rect_x;
    in_clip.y = in_i.rect_y;
    in_clip.w = (in_x2 > {1'b0, scr_w_q}) ? scr_w_q - in_i.rect_x : in_i.rect_w;
    in_clip.h = (in_y2 > {1'b0, scr_h_q}) ? scr_h_q - in_i.rect_y : in_i.rect_h;
  end

  // Overlap test of the current rectangle against the entry just read,
  // with the bounding box they would merge into.
  logic [CoordW:0] cx2, cy2, ex2, ey2, bx2, by2;
  logic            overlap;
  rect_t           bbox;

  always_comb begin
    cx2 = {1'b0, cur_q.x} + {1'b0, cur_q.w};
    cy2 = {1'b0, cur_q.y} + {1'b0, cur_q.h};
    ex2 = {1'b0, ram_rdata.x} + {1'b0, ram_rdata.w};
    ey2 = {1'b0, ram_rdata.y} + {1'b0, ram_rdata.h};
    overlap = ({1'b0, cur_q.x} < ex2) && ({1'b0, ram_rdata.x} < cx2) &&
              ({1'b0, cur_q.y} < ey2) && ({1'b0, ram_rdata.y} < cy2);
    bbox.x = (ram_rdata.x < cur_q.x) ? ram_rdata.x : cur_q.x;
    bbox.y = (ram_rdata.y < cur_q.y) ? ram_rdata.y : cur_q.y;
    bx2    = (ex2 > cx2) ? ex2 : cx2;
    by2    = (ey2 > cy2) ? ey2 : cy2;
    bbox.w = CoordW'(bx2 - {1'b0, bbox.x});
    bbox.h = CoordW'(by2 - {1'b0, bbox.y});
  end

  logic out_free;
  assign out_free    = !ovalid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && !done_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    full_d      = full_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    mrg_d       = mrg_q;
    hit_d       = hit_q;
    hit_pos_d   = hit_pos_q;
    ident_d     = ident_q;
    done_d      = done_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_rect_d  = res_rect_q;
    ord_drop    = 1'b0;
    ord_insert  = 1'b0;
    ord_pos     = idx_q;
    ram_we      = 1'b0;

    // A finished result moves to the output register once it is free.
    if (done_q && out_free) begin
      done_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_rect_d  = '0;
          if (in_i.cmd == CMD_DEQUEUE) begin
            if (cnt_q == '0) begin
              done_d = 1'b1;
            end else if (full_q) begin
              res_found_d = 1'b1;
              res_full_d  = 1'b1;
              full_d      = 1'b0;
              cnt_d       = '0;
              done_d      = 1'b1;
            end else begin
              state_d = ST_DEQ_RD;
            end
          end else if (in_drop || full_q) begin
            done_d = 1'b1;
          end else begin
            cur_d   = in_clip;
            idx_d   = '0;
            hit_d   = 1'b0;
            ident_d = 1'b0;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_DEQ_RD: begin
        ord_pos = '0;
        state_d = ST_DEQ_DATA;
      end
      ST_DEQ_DATA: begin
        res_found_d = 1'b1;
        res_rect_d  = ram_rdata;
        ord_pos     = '0;
        ord_drop    = 1'b1;
        cnt_d       = cnt_q - 1'b1;
        done_d      = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          if (ident_q) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (hit_q) begin
            // Merge: remove the overlapped entry and scan again.
            ord_pos  = hit_pos_q;
            ord_drop = 1'b1;
            cnt_d    = cnt_q - 1'b1;
            cur_d    = mrg_q;
            idx_d    = '0;
            hit_d    = 1'b0;
          end else begin
            state_d = ST_ADD_END;
          end
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (ram_rdata == cur_q) begin
          ident_d = 1'b1;
        end
        if (overlap && !hit_q) begin
          hit_d     = 1'b1;
          hit_pos_d = idx_q;
          mrg_d     = bbox;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ST_SCAN_RD;
      end
      ST_ADD_END: begin
        ord_pos = cnt_q;
        if (cnt_q >= MaxCnt) begin
          cnt_d  = CW'(1);
          full_d = 1'b1;
        end else begin
          ram_we     = 1'b1;
          ord_insert = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      full_q   <= 1'b0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
      hit_q    <= 1'b0;
      ident_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
      ident_q <= ident_d;
      idx_q   <= idx_d;
      if (done_q && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    mrg_q       <= mrg_d;
    hit_pos_q   <= hit_pos_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_rect_q  <= res_rect_d;
    if (done_q && out_free) begin
      out_o.found         <= res_found_q;
      out_o.full_update   <= res_full_q;
      out_o.out_x         <= res_rect_q.x;
      out_o.out_y         <= res_rect_q.y;
      out_o.out_w         <= res_rect_q.w;
      out_o.out_h         <= res_rect_q.h;
      out_o.pending_count <= PendW'(cnt_q);
    end
  end

  assign out_o.valid = ovalid_q;

endmodule

`default_nettype wire

// ----- rtl/drmq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module drmq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/drmq_order.sv -----
`timescale 1ns / 1ps
`default_nettype none

// List order of the store: a permutation of slot numbers. Positions below
// the entry count are the live list, head first; the rest are free slots.
module drmq_order #(
  parameter int unsigned MaxRects = 8
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         drop_i,
  input  wire                         insert_i,
  input  wire  [$clog2(MaxRects+1)-1:0] pos_i,
  output logic [$clog2(MaxRects)-1:0]   slot_o
);

  localparam int unsigned AW = $clog2(MaxRects);

  logic [AW-1:0] ord_q [MaxRects];
  logic [AW-1:0] ord_d [MaxRects];
  logic [AW-1:0] pos;

  assign pos    = pos_i[AW-1:0];
  assign slot_o = ord_q[pos];

  always_comb begin
    for (int j = 0; j < MaxRects; j++) begin
      ord_d[j] = ord_q[j];
    end
    if (drop_i) begin
      // Remove position pos and park its slot at the tail.
      for (int j = 0; j < MaxRects - 1; j++) begin
        if (AW'(j) >= pos) begin
          ord_d[j] = ord_q[j+1];
        end
      end
      ord_d[MaxRects-1] = ord_q[pos];
    end else if (insert_i) begin
      // Take the first free slot (position pos) to the head.
      ord_d[0] = ord_q[pos];
      for (int j = 1; j < MaxRects; j++) begin
        if (AW'(j) <= pos) begin
          ord_d[j] = ord_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MaxRects; j++) begin
        ord_q[j] <= AW'(j);
      end
    end else begin
      for (int j = 0; j < MaxRects; j++) begin
        ord_q[j] <= ord_d[j];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/drmq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module drmq_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid,
  input wire       out_ready,
  input wire       found,
  input wire       full_update,
  input wire [7:0] out_x,
  input wire [7:0] out_y,
  input wire [7:0] out_w,
  input wire [7:0] out_h,
  input wire [3:0] pending_count
);

  // A result without an entry carries no update and no rectangle.
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !found |-> !full_update && out_x == 8'd0 && out_y == 8'd0 &&
    out_w == 8'd0 && out_h == 8'd0)
    else $error("result without entry carries data");

  // A full update empties the list and carries no rectangle.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && full_update |-> pending_count == 4'd0 && out_w == 8'd0 &&
    out_h == 8'd0)
    else $error("full update with data or pending entries");

  // A dequeued rectangle is never empty.
  a_rect_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && found && !full_update |-> out_w != 8'd0 && out_h != 8'd0)
    else $error("empty rectangle dequeued");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pending_count) && $stable(found))
    else $error("stalled result changed");

endmodule

bind dirty_rectangle_merge_queue_top drmq_checker u_drmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .found         (out_o.found),
  .full_update   (out_o.full_update),
  .out_x         (out_o.out_x),
  .out_y         (out_o.out_y),
  .out_w         (out_o.out_w),
  .out_h         (out_o.out_h),
  .pending_count (out_o.pending_count)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import drmq_pkg::*;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned CycleLimit = 400000;

  // One expected result, with the same fields the block reports.
  typedef struct {
    logic       found;
    logic       full_update;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic [3:0] pending;
  } update_t;

  logic clk_i;
  logic rst_ni;

  drmq_in_if  in_if ();
  drmq_out_if out_if ();
  drmq_cfg_if cfg_if ();

  dirty_rectangle_merge_queue_top #(
    .MAX_RECTS(NumSlots)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  // Predicted state: a private copy of the pending list and the screen size.
  rect_t       region_list[NumSlots];
  int unsigned region_count;
  bit          full_redraw;
  logic [7:0]  scr_w;
  logic [7:0]  scr_h;

  update_t     pending_updates[$];
  int          error_count;
  int unsigned cycle_count;
  bit          sender_done;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The run is cut off at a generous cycle count in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[dirty_rectangle_merge_queue_top] ERROR");
      $finish;
    end
  end

  // Removes entry idx and closes the gap, as the list keeps newest at index 0.
  function automatic void remove_region(int unsigned idx);
    for (int unsigned i = idx; i + 1 < region_count; i++) begin
      region_list[i] = region_list[i + 1];
    end
    if (region_count > 0) region_count--;
  endfunction

  // Adds a rectangle: clip, skip duplicates, absorb overlapping entries into the
  // bounding box until nothing more overlaps, then push it at the head, or turn a full list into a full redraw.
  function automatic void insert_region(int unsigned x, int unsigned y,
                                        int unsigned w, int unsigned h);
    bit merged;
    bit dup;
    rect_t key;
    int unsigned ex, ey, ex2, ey2, x2, y2;
    if (w == 0 || h == 0) return;
    if (x >= scr_w || y >= scr_h) return;
    if (x + w > scr_w) w = scr_w - x;
    if (y + h > scr_h) h = scr_h - y;
    if (full_redraw) return;
    do begin
      merged = 1'b0;
      key = '{h: h[7:0], w: w[7:0], y: y[7:0], x: x[7:0]};
      dup = 1'b0;
      for (int unsigned i = 0; i < region_count; i++) begin
        if (region_list[i] == key) dup = 1'b1;
      end
      if (dup) return;
      for (int unsigned i = 0; i < region_count; i++) begin
        ex  = region_list[i].x;
        ey  = region_list[i].y;
        ex2 = ex + region_list[i].w;
        ey2 = ey + region_list[i].h;
        x2  = x + w;
        y2  = y + h;
        if (x < ex2 && ex < x2 && y < ey2 && ey < y2) begin
          remove_region(i);
          if (ex < x) x = ex;
          if (ey < y) y = ey;
          if (ex2 > x2) x2 = ex2;
          if (ey2 > y2) y2 = ey2;
          w = (x2 - x) & 8'hFF;
          h = (y2 - y) & 8'hFF;
          merged = 1'b1;
          break;
        end
      end
    end while (merged);
    if (region_count >= NumSlots) begin
      region_count = 1;
      full_redraw  = 1'b1;
      return;
    end
    for (int unsigned i = region_count; i > 0; i--) begin
      region_list[i] = region_list[i - 1];
    end
    region_list[0] = '{h: h[7:0], w: w[7:0], y: y[7:0], x: x[7:0]};
    region_count++;
  endfunction

  // Works out the single result that one accepted item causes.
  function automatic update_t predict_update(logic cmd, logic [7:0] x, logic [7:0] y,
                                             logic [7:0] w, logic [7:0] h);
    update_t u;
    u = '{default: '0};
    if (cmd == CMD_DEQUEUE) begin
      if (region_count > 0) begin
        u.found = 1'b1;
        if (full_redraw) begin
          u.full_update = 1'b1;
          full_redraw   = 1'b0;
          region_count  = 0;
        end else begin
          u.x = region_list[0].x;
          u.y = region_list[0].y;
          u.w = region_list[0].w;
          u.h = region_list[0].h;
          remove_region(0);
        end
      end
    end else begin
      insert_region(x, y, w, h);
    end
    u.pending = region_count[3:0];
    return u;
  endfunction

  // Sends one item after a random gap and records what it should produce.
  // Valid stays high across back-to-back items and drops only for a gap or a drain.
  task automatic send_item(logic cmd, logic [7:0] x, logic [7:0] y,
                           logic [7:0] w, logic [7:0] h);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.cmd    <= cmd;
    in_if.rect_x <= x;
    in_if.rect_y <= y;
    in_if.rect_w <= w;
    in_if.rect_h <= h;
    do @(posedge clk_i); while (!in_if.ready);
    pending_updates.push_back(predict_update(cmd, x, y, w, h));
  endtask

  task automatic send_add(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    send_item(CMD_ADD, x[7:0], y[7:0], w[7:0], h[7:0]);
  endtask

  task automatic send_dequeue();
    send_item(CMD_DEQUEUE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Waits until every result is back, then lets a worst-case add finish.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (2 * (NumSlots + 1) * (NumSlots + 1) + 10) @(posedge clk_i);
  endtask

  // Register writes happen only once the block has gone idle.
  task automatic write_screen(logic [7:0] width, logic [7:0] height);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SCREEN_WIDTH;
    cfg_if.data  <= width;
    do @(posedge clk_i); while (!cfg_if.ready);
    scr_w = width;
    cfg_if.index <= CFG_SCREEN_HEIGHT;
    cfg_if.data  <= height;
    do @(posedge clk_i); while (!cfg_if.ready);
    scr_h = height;
    cfg_if.valid <= 1'b0;
  endtask

  // Random add: mostly small on-screen rectangles so that overlaps and merges
  // are common, with some fully random fields to cover every input bit.
  task automatic send_random_add();
    if ($urandom_range(0, 4) == 0) begin
      send_add($urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
    end else begin
      send_add($urandom_range(0, scr_w - 1), $urandom_range(0, scr_h - 1),
               $urandom_range(0, 12), $urandom_range(0, 6));
    end
  endtask

  task automatic send_random_mix(int unsigned count, int unsigned deq_weight);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < deq_weight) send_dequeue();
      else send_random_add();
    end
  endtask

  // Field extremes, dropped and clipped adds, duplicates, a merge and a dequeue
  // from an empty list.
  task automatic test_directed();
    send_dequeue();
    send_add(0, 0, 0, 5);
    send_add(0, 0, 5, 0);
    send_add(80, 0, 1, 1);
    send_add(0, 25, 1, 1);
    send_add(255, 255, 255, 255);
    send_add(70, 20, 255, 255);
    send_add(70, 20, 255, 255);
    send_add(0, 0, 2, 2);
    send_add(1, 1, 3, 3);
    send_add(10, 10, 1, 1);
    send_add(0, 0, 1, 1);
    send_dequeue();
    send_dequeue();
    send_dequeue();
    send_dequeue();
    send_dequeue();
  endtask

  // Nine disjoint rectangles overflow the store into a single full update,
  // which then absorbs further adds until it is dequeued.
  task automatic test_overflow();
    for (int unsigned i = 0; i < NumSlots + 1; i++) send_add(i * 3, 0, 1, 1);
    send_add(5, 5, 2, 2);
    send_dequeue();
    send_dequeue();
  endtask

  // Random traffic under several screen sizes, the register extremes included.
  task automatic test_random();
    send_random_mix(120, 3);
    drain();
    write_screen(8'd255, 8'd255);
    send_random_mix(80, 3);
    write_screen(8'd1, 8'd1);
    send_random_mix(40, 4);
    write_screen(8'd16, 8'd8);
    send_random_mix(80, 3);
    write_screen(8'd80, 8'd25);
    send_random_mix(80, 4);
  endtask

  // Result side: after each result ready stays low while a random hold counts down, which it
  // does only while a result is waiting; compare against the oldest expectation.
  initial begin
    update_t e;
    int unsigned hold;
    out_if.ready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_updates.size() == 0) begin
          $display("%0t: unexpected result", $time);
          error_count++;
        end else begin
          e = pending_updates.pop_front();
          if (out_if.found !== e.found || out_if.full_update !== e.full_update ||
              out_if.out_x !== e.x || out_if.out_y !== e.y ||
              out_if.out_w !== e.w || out_if.out_h !== e.h ||
              out_if.pending_count !== e.pending) begin
            $display("%0t: expected f=%b fu=%b x=%0d y=%0d w=%0d h=%0d n=%0d",
                     $time, e.found, e.full_update, e.x, e.y, e.w, e.h, e.pending);
            $display("%0t: actual   f=%b fu=%b x=%0d y=%0d w=%0d h=%0d n=%0d",
                     $time, out_if.found, out_if.full_update, out_if.out_x,
                     out_if.out_y, out_if.out_w, out_if.out_h, out_if.pending_count);
            error_count++;
          end
        end
        hold = sender_done ? 0 : $urandom_range(0, 5);
      end else if (out_if.valid && hold != 0) begin
        hold--;
      end
      out_if.ready <= (hold == 0);
    end
  end

  initial begin
    sender_done  = 1'b0;
    region_count = 0;
    full_redraw  = 1'b0;
    scr_w        = ScreenWidthRst;
    scr_h        = ScreenHeightRst;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_ADD;
    in_if.rect_x = '0;
    in_if.rect_y = '0;
    in_if.rect_w = '0;
    in_if.rect_h = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SCREEN_WIDTH;
    cfg_if.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_overflow();
    test_random();

    sender_done = 1'b1;
    drain();
    if (error_count == 0) begin
      $display("[dirty_rectangle_merge_queue_top] OK");
    end else begin
      $display("[dirty_rectangle_merge_queue_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/drmq_pkg.sv
rtl/drmq_if.sv
rtl/drmq_ram.sv
rtl/drmq_order.sv
rtl/dirty_rectangle_merge_queue_top.sv
rtl/drmq_checker.sv
sim/testbench.sv
